FILE: rtl/cpt_pkg.sv
// Shared types and constants for the camera point transform block.
// Holds the register set, queue item layouts and default parameter values.
// No dependencies.
`default_nettype none
package cpt_pkg;

    localparam int HALF_WIDTH_DEF  = 320;
    localparam int HALF_HEIGHT_DEF = 240;
    localparam int MID_DEPTH       = 16;
    localparam int OUT_DEPTH       = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAM_X       = 3'd0,
        CFG_CAM_Y       = 3'd1,
        CFG_CAM_Z       = 3'd2,
        CFG_SIN_YAW     = 3'd3,
        CFG_COS_YAW     = 3'd4,
        CFG_PITCH_SHEAR = 3'd5,
        CFG_PROJ_SCALE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_yaw;
        logic signed [31:0] pitch_shear;
        logic        [30:0] proj_scale;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               behind;
    } t_mid_item;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind;
    } t_res_item;

endpackage
`default_nettype wire

FILE: rtl/cpt_fifo.sv
// Small synchronous queue with registered storage and head read.
// Generic over width and depth; used between front and back and at the output.
// No dependencies.
`default_nettype none
module cpt_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic             w_pop;

    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= n_wr;
            if (w_pop)  r_rd <= n_rd;
            r_cnt <= r_cnt + CW'(i_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

FILE: rtl/cpt_front.sv
// Front pipeline: camera offset, yaw rotation, pitch shear, behind test.
// Five stages, never stalls; depends on cpt_pkg.
`default_nettype none
module cpt_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cpt_pkg::t_cfg      i_cfg,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    output logic                    o_valid,
    output cpt_pkg::t_mid_item      o_item
);
    import cpt_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v[49:31] == {19{v[49]}}) return v[31:0];
        return v[49] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [32:0] r_tx, r_tz, r_ty1;
    logic signed [48:0] r_p_xs, r_p_zc, r_p_xc, r_p_zs;
    logic signed [32:0] r_ty2, r_ty3, r_ty4;
    logic signed [31:0] r_rx3, r_rz3, r_rx4, r_rz4;
    logic signed [63:0] r_prod;
    t_mid_item          r_item;

    logic signed [49:0] n_sum_x, n_sum_z, n_rnd_x, n_rnd_z;
    logic signed [63:0] n_sh;
    logic signed [49:0] n_ry;

    always_comb begin
        n_sum_x = 50'(r_p_xs) - 50'(r_p_zc);
        n_sum_z = 50'(r_p_xc) + 50'(r_p_zs);
        n_rnd_x = (n_sum_x + 50'sd8192) >>> 14;
        n_rnd_z = (n_sum_z + 50'sd8192) >>> 14;
        n_sh    = (r_prod + 64'sd32768) >>> 16;
        n_ry    = 50'(r_ty4) + $signed(n_sh[49:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx   <= 33'(i_pos_x) - 33'(i_cfg.cam_x);
        r_tz   <= 33'(i_pos_y) - 33'(i_cfg.cam_y);
        r_ty1  <= 33'(i_pos_z) - 33'(i_cfg.cam_z);
        r_p_xs <= 49'(r_tx) * 49'($signed(i_cfg.sin_yaw));
        r_p_zc <= 49'(r_tz) * 49'($signed(i_cfg.cos_yaw));
        r_p_xc <= 49'(r_tx) * 49'($signed(i_cfg.cos_yaw));
        r_p_zs <= 49'(r_tz) * 49'($signed(i_cfg.sin_yaw));
        r_ty2  <= r_ty1;
        r_rx3  <= sat32(n_rnd_x);
        r_rz3  <= sat32(n_rnd_z);
        r_ty3  <= r_ty2;
        r_prod <= 64'(r_rz3) * 64'($signed(i_cfg.pitch_shear));
        r_rx4  <= r_rx3;
        r_rz4  <= r_rz3;
        r_ty4  <= r_ty3;
        r_item.rot_x  <= r_rx4;
        r_item.rot_z  <= r_rz4;
        r_item.rot_y  <= sat32(n_ry);
        r_item.behind <= !r_rz4[31];
    end

    assign o_valid = r_v5;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: rtl/cpt_back.sv
// Back pipeline: projection multiply and 17-step restoring divide per axis.
// Pops the middle queue against output queue credit; depends on cpt_pkg.
`default_nettype none
module cpt_back #(
    parameter int HALF_WIDTH  = cpt_pkg::HALF_WIDTH_DEF,
    parameter int HALF_HEIGHT = cpt_pkg::HALF_HEIGHT_DEF,
    parameter int OUT_DEPTH   = cpt_pkg::OUT_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic        [30:0] i_proj_scale,
    input  wire logic               i_mid_empty,
    input  wire cpt_pkg::t_mid_item i_mid_item,
    output logic                    o_mid_pop,
    input  wire logic               i_out_pop,
    output logic                    o_out_push,
    output cpt_pkg::t_res_item      o_out_item
);
    import cpt_pkg::*;

    localparam int QB = 17;
    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam logic signed [18:0] CX = 19'(HALF_WIDTH);
    localparam logic signed [18:0] CY = 19'(HALF_HEIGHT);

    typedef struct packed {
        logic [48:0]   rem;
        logic [QB-1:0] q;
        logic          neg;
        logic          fnz;
        logic          ov;
    } t_lane;

    typedef struct packed {
        t_lane       lx;
        t_lane       ly;
        logic [31:0] m;
        t_mid_item   item;
    } t_pipe;

    function automatic logic signed [15:0] finish(input t_lane l,
                                                  input logic signed [18:0] c);
        logic signed [18:0] t;
        t = l.neg ? c - $signed({2'b00, l.q}) : c + $signed({2'b00, l.q});
        if (l.neg && (l.fnz || (l.rem != '0)) && (t > 19'sd0)) t = t - 19'sd1;
        if (l.ov) return l.neg ? 16'sh8000 : 16'sh7fff;
        if (t > 19'sd32767) return 16'sh7fff;
        if (t < -19'sd32768) return 16'sh8000;
        return t[15:0];
    endfunction

    function automatic t_lane lane_start(input logic [45:0] n, input logic neg,
                                         input logic fnz, input logic [31:0] m);
        t_lane l;
        l.rem = 49'(n);
        l.q   = '0;
        l.neg = neg;
        l.fnz = fnz;
        l.ov  = (49'(n) >= {m, 17'b0});
        return l;
    endfunction

    logic [CW-1:0]      r_cred;
    logic               r_v0, r_v1, r_v2, r_vo;
    t_mid_item          r_it0, r_it1, r_it2;
    logic signed [62:0] r_nx, r_ny;
    logic        [31:0] r_m1, r_m2;
    logic        [62:0] n_mx, n_my;
    logic        [45:0] r_dx, r_dy;
    logic               r_negx, r_negy, r_fx, r_fy;
    logic               r_pv [QB+1];
    t_pipe              r_pipe [QB+1];
    t_res_item          r_out;

    assign o_mid_pop = !i_mid_empty && (r_cred != CW'(OUT_DEPTH));

    always_comb begin
        n_mx = r_nx[62] ? 63'(-r_nx) : 63'(r_nx);
        n_my = r_ny[62] ? 63'(-r_ny) : 63'(r_ny);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_pv[0] <= 1'b0;
            r_vo   <= 1'b0;
        end else begin
            r_cred  <= r_cred + CW'(o_mid_pop) - CW'(i_out_pop);
            r_v0    <= o_mid_pop;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_pv[0] <= r_v2;
            r_vo    <= r_pv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_it0 <= i_mid_item;
        r_nx  <= 63'(r_it0.rot_x) * $signed({32'b0, i_proj_scale});
        r_ny  <= 63'(r_it0.rot_y) * $signed({32'b0, i_proj_scale});
        r_m1  <= 32'(-33'(r_it0.rot_z));
        r_it1 <= r_it0;
        r_dx   <= n_mx[61:16];
        r_dy   <= n_my[61:16];
        r_fx   <= |n_mx[15:0];
        r_fy   <= |n_my[15:0];
        r_negx <= r_nx[62];
        r_negy <= r_ny[62];
        r_m2   <= r_m1;
        r_it2  <= r_it1;
        r_pipe[0].lx   <= lane_start(r_dx, r_negx, r_fx, r_m2);
        r_pipe[0].ly   <= lane_start(r_dy, r_negy, r_fy, r_m2);
        r_pipe[0].m    <= r_m2;
        r_pipe[0].item <= r_it2;
    end

    for (genvar s = 1; s <= QB; s++) begin : g_div
        localparam int K = QB - s;
        logic [48:0] w_d;
        t_pipe       n_p;

        assign w_d = 49'(r_pipe[s-1].m) << K;

        always_comb begin
            n_p = r_pipe[s-1];
            if (n_p.lx.rem >= w_d) begin
                n_p.lx.rem  = n_p.lx.rem - w_d;
                n_p.lx.q[K] = 1'b1;
            end
            if (n_p.ly.rem >= w_d) begin
                n_p.ly.rem  = n_p.ly.rem - w_d;
                n_p.ly.q[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[s] <= 1'b0;
            end else begin
                r_pv[s] <= r_pv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_pipe[s] <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.rot_x  <= r_pipe[QB].item.rot_x;
        r_out.rot_y  <= r_pipe[QB].item.rot_y;
        r_out.rot_z  <= r_pipe[QB].item.rot_z;
        r_out.behind <= r_pipe[QB].item.behind;
        r_out.screen_x <= r_pipe[QB].item.behind ? 16'sd0 : finish(r_pipe[QB].lx, CX);
        r_out.screen_y <= r_pipe[QB].item.behind ? 16'sd0 : finish(r_pipe[QB].ly, CY);
    end

    assign o_out_push = r_vo;
    assign o_out_item = r_out;

endmodule
`default_nettype wire

FILE: rtl/camera_point_transform_project.sv
// Camera point transform and perspective projection, one point per request.
// Throughput: one request per cycle sustained, result queue permitting.
// The 17-step divide pipeline in the back end makes up most of the path from accept to result.
// Reset (synchronous, active low) empties both queues and loads register defaults.
`default_nettype none
module camera_point_transform_project #(
    parameter int HALF_WIDTH  = cpt_pkg::HALF_WIDTH_DEF,
    parameter int HALF_HEIGHT = cpt_pkg::HALF_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cpt_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [cpt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic signed [31:0]               i_pos_x,
    input  wire logic signed [31:0]               i_pos_y,
    input  wire logic signed [31:0]               i_pos_z,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic signed [31:0]                    o_rot_x,
    output logic signed [31:0]                    o_rot_y,
    output logic signed [31:0]                    o_rot_z,
    output logic signed [15:0]                    o_screen_x,
    output logic signed [15:0]                    o_screen_y,
    output logic                                  o_behind_camera
);
    import cpt_pkg::*;

    localparam int CAW = $clog2(MID_DEPTH + 1);

    t_cfg       r_cfg;
    logic [CAW-1:0] r_cred;
    logic       w_acc;
    logic       w_f_valid;
    t_mid_item  w_f_item;
    logic       w_mid_empty;
    logic       w_mid_pop;
    t_mid_item  w_mid_item;
    logic       w_out_push;
    t_res_item  w_out_item;
    t_res_item  w_head;
    logic       w_out_pop;

    assign full      = (r_cred == CAW'(MID_DEPTH));
    assign w_acc     = push && !full;
    assign w_out_pop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x       <= '0;
            r_cfg.cam_y       <= '0;
            r_cfg.cam_z       <= '0;
            r_cfg.sin_yaw     <= '0;
            r_cfg.cos_yaw     <= 16'sd16384;
            r_cfg.pitch_shear <= '0;
            r_cfg.proj_scale  <= 31'd65536;
            r_cred            <= '0;
        end else begin
            r_cred <= r_cred + CAW'(w_acc) - CAW'(w_mid_pop);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_CAM_X:       r_cfg.cam_x       <= i_cfg_data;
                    CFG_CAM_Y:       r_cfg.cam_y       <= i_cfg_data;
                    CFG_CAM_Z:       r_cfg.cam_z       <= i_cfg_data;
                    CFG_SIN_YAW:     r_cfg.sin_yaw     <= i_cfg_data[15:0];
                    CFG_COS_YAW:     r_cfg.cos_yaw     <= i_cfg_data[15:0];
                    CFG_PITCH_SHEAR: r_cfg.pitch_shear <= i_cfg_data;
                    CFG_PROJ_SCALE:  r_cfg.proj_scale  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    cpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_cfg   (r_cfg),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .o_valid (w_f_valid),
        .o_item  (w_f_item)
    );

    cpt_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(t_mid_item))
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_item),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_item),
        .o_empty (w_mid_empty)
    );

    cpt_back #(
        .HALF_WIDTH  (HALF_WIDTH),
        .HALF_HEIGHT (HALF_HEIGHT),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_proj_scale (r_cfg.proj_scale),
        .i_mid_empty  (w_mid_empty),
        .i_mid_item   (w_mid_item),
        .o_mid_pop    (w_mid_pop),
        .i_out_pop    (w_out_pop),
        .o_out_push   (w_out_push),
        .o_out_item   (w_out_item)
    );

    cpt_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_res_item))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_item),
        .i_pop   (w_out_pop),
        .o_data  (w_head),
        .o_empty (empty)
    );

    assign o_rot_x         = w_head.rot_x;
    assign o_rot_y         = w_head.rot_y;
    assign o_rot_z         = w_head.rot_z;
    assign o_screen_x      = w_head.screen_x;
    assign o_screen_y      = w_head.screen_y;
    assign o_behind_camera = w_head.behind;

`ifndef ASSERT_OFF
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= CAW'(MID_DEPTH))
        else $error("middle queue credit overrun");

    a_mid_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid_empty)
        else $error("pop from empty middle queue");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_behind_camera) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("screen position not cleared for point behind camera");

    a_full_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_mid_pop) |=> (r_cred == $past(r_cred) + 1'b1))
        else $error("credit not taken on accept");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the camera point transform and projection block.
// Predicts each result from the written registers and compares all fields.
// Depends on cpt_pkg and camera_point_transform_project.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cpt_pkg::*;

    localparam int HW = HALF_WIDTH_DEF;
    localparam int HH = HALF_HEIGHT_DEF;
    localparam int LATENCY = 28;
    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic push;
    logic full;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic empty;
    logic pop;
    logic signed [31:0] o_rot_x, o_rot_y, o_rot_z;
    logic signed [15:0] o_screen_x, o_screen_y;
    logic o_behind_camera;

    camera_point_transform_project dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .empty(empty), .pop(pop),
        .o_rot_x(o_rot_x), .o_rot_y(o_rot_y), .o_rot_z(o_rot_z),
        .o_screen_x(o_screen_x), .o_screen_y(o_screen_y),
        .o_behind_camera(o_behind_camera)
    );

    t_cfg cam_regs;
    t_res_item expected_points[$];
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit hold_pop;
    int pop_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint to_screen(longint c, longint num, longint den);
        longint q, r, f;
        q = num / den;
        r = num % den;
        if (r < 0) q = q - 1;
        f = c + q;
        if (f < 0 && r != 0) f = f + 1;
        return clamp(f, -32768, 32767);
    endfunction

    function automatic t_res_item project_point(logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] pz);
        t_res_item res;
        longint tx, ty, tz, s, c, rx, ry, rz, den;
        tx = longint'(px) - longint'(cam_regs.cam_x);
        tz = longint'(py) - longint'(cam_regs.cam_y);
        ty = longint'(pz) - longint'(cam_regs.cam_z);
        s = longint'(cam_regs.sin_yaw);
        c = longint'(cam_regs.cos_yaw);
        rx = clamp(floor_shift(tx * s - tz * c + 8192, 14), -64'sd2147483648, 2147483647);
        rz = clamp(floor_shift(tx * c + tz * s + 8192, 14), -64'sd2147483648, 2147483647);
        ry = clamp(ty + floor_shift(rz * longint'(cam_regs.pitch_shear) + 32768, 16),
                   -64'sd2147483648, 2147483647);
        res.rot_x = rx[31:0];
        res.rot_y = ry[31:0];
        res.rot_z = rz[31:0];
        res.behind = (rz >= 0);
        res.screen_x = '0;
        res.screen_y = '0;
        if (rz < 0) begin
            den = (-rz) * 65536;
            res.screen_x = 16'(to_screen(HW, rx * longint'({1'b0, cam_regs.proj_scale}), den));
            res.screen_y = 16'(to_screen(HH, ry * longint'({1'b0, cam_regs.proj_scale}), den));
        end
        return res;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CAM_X: cam_regs.cam_x = value;
            CFG_CAM_Y: cam_regs.cam_y = value;
            CFG_CAM_Z: cam_regs.cam_z = value;
            CFG_SIN_YAW: cam_regs.sin_yaw = value[15:0];
            CFG_COS_YAW: cam_regs.cos_yaw = value[15:0];
            CFG_PITCH_SHEAR: cam_regs.pitch_shear = value;
            CFG_PROJ_SCALE: cam_regs.proj_scale = value[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
            logic [15:0] sn, logic [15:0] cs, logic [31:0] sh, logic [31:0] sc);
        write_reg(CFG_CAM_X, cx);
        write_reg(CFG_CAM_Y, cy);
        write_reg(CFG_CAM_Z, cz);
        write_reg(CFG_SIN_YAW, {{16{sn[15]}}, sn});
        write_reg(CFG_COS_YAW, {{16{cs[15]}}, cs});
        write_reg(CFG_PITCH_SHEAR, sh);
        write_reg(CFG_PROJ_SCALE, sc);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
            bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        do @(posedge i_clk); while (full);
        expected_points.push_back(project_point(px, py, pz));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                32'hFFF6_0000};
        foreach (ext[k]) send_point(ext[k], ext[(k + 1) % 6], ext[(k + 2) % 6], 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h000A_0000, 32'h0, 1'b0);
        send_point(32'h0001_0000, 32'hFFF6_0000, 32'h0002_0000, 1'b0);
        send_point(32'h7FFF_0000, 32'hFFFF_0000, 32'h8000_0000, 1'b0);
        send_point(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        wait_drained();
        set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000, 16'hC000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        foreach (ext[k]) send_point(ext[k], ext[(k + 3) % 6], ext[(k + 1) % 6], 1'b0);
        wait_drained();
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h7FFF,
                   32'h8000_0000, 32'h0);
        foreach (ext[k]) send_point(ext[k], ext[(k + 2) % 6], ext[(k + 4) % 6], 1'b0);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            set_camera(rand_coord(), rand_coord(), rand_coord(),
                       (phase == 7) ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384),
                       (phase == 7) ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384),
                       (phase % 2) ? $urandom : 32'($signed($urandom_range(0, 131072)) - 65536),
                       (phase == 3) ? 32'h0 : $urandom);
            repeat (170) send_point(rand_coord(), rand_coord(), rand_coord(),
                                    $urandom_range(0, 3) != 0);
            wait_drained();
        end
        write_reg(t_cfg_idx'(3'd7), $urandom);
    endtask

    task automatic test_backpressure();
        hold_pop = 1'b1;
        repeat (120) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        push <= 1'b0;
        wait (!hold_pop);
        wait_drained();
    endtask

    initial begin
        pop_hold_cycles = 0;
        wait (hold_pop);
        while (pop_hold_cycles < 300) begin
            @(posedge i_clk);
            pop_hold_cycles++;
        end
        hold_pop = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        push = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        mismatches = 0;
        timed_out = 1'b0;
        hold_pop = 1'b0;
        cam_regs = '{cam_x: 0, cam_y: 0, cam_z: 0, sin_yaw: 0, cos_yaw: 16384,
                     pitch_shear: 0, proj_scale: 65536};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_settings();
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("PASS camera_point_transform_project");
        end else begin
            $display("FAIL camera_point_transform_project");
        end
        $finish;
    end

    initial begin
        int gap;
        pop = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap != 0 || hold_pop) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_pop) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty || !i_rst_n);
        end
    end

    always @(posedge i_clk) begin
        t_res_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result rot_x=%0d", o_rot_x);
            end else begin
                want = expected_points.pop_front();
                if (o_rot_x !== want.rot_x || o_rot_y !== want.rot_y ||
                    o_rot_z !== want.rot_z || o_screen_x !== want.screen_x ||
                    o_screen_y !== want.screen_y || o_behind_camera !== want.behind) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                                 want.rot_x, want.rot_y, want.rot_z, want.screen_x,
                                 want.screen_y, want.behind, o_rot_x, o_rot_y, o_rot_z,
                                 o_screen_x, o_screen_y, o_behind_camera);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n || i_cfg_we || hold_pop)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL camera_point_transform_project");
            $finish;
        end
    end

    initial idle_cycles = 0;
endmodule
`default_nettype wire
